// ----- rtl/rse_pkg.sv -----
// Shared types and constants for the RPN stack evaluator.
// Used by rse_alu and rpn_stack_evaluator_top; no dependencies.
`default_nettype none
package rse_pkg;

  localparam int WORD_W      = 64;
  localparam int STACK_DEPTH = 64;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int STEP_W      = 6;

  localparam logic [STEP_W-1:0] LAST_STEP_WIDE = STEP_W'(WORD_W - 1);
  localparam logic [STEP_W-1:0] LAST_STEP_ROOT = STEP_W'(WORD_W / 2 - 1);
  localparam logic [WORD_W-1:0] LOG_BASE_MIN   = WORD_W'(2);
  localparam logic [WORD_W-1:0] ROOT_BIT_INIT  = WORD_W'(1) << (WORD_W - 2);

  // token codes
  localparam logic [3:0] FN_PUSH = 4'd0;
  localparam logic [3:0] FN_ADD  = 4'd1;
  localparam logic [3:0] FN_SUB  = 4'd2;
  localparam logic [3:0] FN_MUL  = 4'd3;
  localparam logic [3:0] FN_DIV  = 4'd4;
  localparam logic [3:0] FN_POW  = 4'd5;
  localparam logic [3:0] FN_LOG  = 4'd6;
  localparam logic [3:0] FN_SQRT = 4'd7;
  localparam logic [3:0] FN_SEL  = 4'd8;
  localparam logic [3:0] FN_END  = 4'd9;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL_B,
    ST_SEL_A,
    ST_FETCH_A,
    ST_EXEC,
    ST_ALU_WAIT,
    ST_POW_STEP,
    ST_POW_MR,
    ST_POW_MB,
    ST_LOG_STEP,
    ST_LOG_WAIT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/rse_alu.sv -----
// Iterative shared arithmetic unit: shift-add multiply, restoring unsigned
// divide and bitwise floor square root, one step per cycle. Uses rse_pkg.
`default_nettype none
module rse_alu import rse_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire alu_req_t          req,
  input  wire logic [WORD_W-1:0] x,
  input  wire logic [WORD_W-1:0] y,
  output alu_rsp_t               rsp,
  output logic      [WORD_W-1:0] res
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  alu_op_t           op;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] aux;

  logic [WORD_W:0]   div_sh;
  logic [WORD_W:0]   div_diff;
  logic [WORD_W-1:0] root_t;
  logic [STEP_W-1:0] last_step;

  // one step of each routine
  always_comb begin
    div_sh    = {rem, quo[WORD_W-1]};
    div_diff  = div_sh - {1'b0, aux};
    root_t    = acc + aux;
    last_step = (op == ALU_SQRT) ? LAST_STEP_ROOT : LAST_STEP_WIDE;
  end

  // control: busy flag, step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: load on start, advance one step per busy cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      op <= req.op;
      unique case (req.op)
        ALU_MUL: begin
          acc <= '0;
          aux <= x;
          quo <= y;
        end
        ALU_DIV: begin
          rem <= '0;
          quo <= x;
          aux <= y;
        end
        ALU_SQRT: begin
          acc <= '0;
          rem <= x;
          aux <= ROOT_BIT_INIT;
        end
        default: begin
          acc <= '0;
        end
      endcase
    end else if (busy) begin
      unique case (op)
        ALU_MUL: begin
          if (quo[0]) acc <= acc + aux;
          aux <= aux << 1;
          quo <= quo >> 1;
        end
        ALU_DIV: begin
          rem <= div_diff[WORD_W] ? div_sh[WORD_W-1:0] : div_diff[WORD_W-1:0];
          quo <= {quo[WORD_W-2:0], ~div_diff[WORD_W]};
        end
        ALU_SQRT: begin
          if (rem >= root_t) begin
            rem <= rem - root_t;
            acc <= (acc >> 1) + aux;
          end else begin
            acc <= acc >> 1;
          end
          aux <= aux >> 2;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign res      = (op == ALU_DIV) ? quo : acc;
  assign rsp.busy = busy;
  assign rsp.done = done;

  // a new request never lands on a running routine
  assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("alu start while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("alu done while busy");
  assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("alu did not start");

endmodule
`default_nettype wire

// ----- rtl/rpn_stack_evaluator_top.sv -----
// pow squares once per exponent bit and also multiplies into the result when the bit is set
// (two ALU passes); log runs one divide per unit of the result.
// One token at a time; the stack RAM has one registered read port.
// Reset (rst, synchronous) empties the stack, clears the error and out_valid.
`default_nettype none
module rpn_stack_evaluator_top import rse_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [3:0]  func,
  input  wire logic signed [63:0] operand_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [63:0]      result_value,
  output logic                    status
);

  state_t state, state_next;

  logic [COUNT_W-1:0] count;
  logic               err;
  logic [WORD_W-1:0]  top;
  logic [3:0]         func_reg;
  logic [WORD_W-1:0]  opa;
  logic [WORD_W-1:0]  opb;
  logic [WORD_W-1:0]  acc;

  logic [WORD_W-1:0]  mem [STACK_DEPTH];
  logic [WORD_W-1:0]  rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_addr;
  logic [WORD_W-1:0]  mem_wdata;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic [WORD_W-1:0]  alu_x;
  logic [WORD_W-1:0]  alu_y;
  logic [WORD_W-1:0]  alu_res;

  logic               accept;
  logic               take;
  logic               push_we;
  logic               wb_en;
  logic [WORD_W-1:0]  wb_data;
  logic [IDX_W-1:0]   wb_addr;
  logic [COUNT_W-1:0] wb_count;
  logic               err_set;
  logic               end_bad;

  logic               is_full;
  logic               is_bin;
  logic               pow_bad;
  logic               log_bad;
  logic [WORD_W-1:0]  abs_a;
  logic [WORD_W-1:0]  abs_b;
  logic [WORD_W-1:0]  quo_signed;

  rse_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .x   (alu_x),
    .y   (alu_y),
    .rsp (alu_rsp),
    .res (alu_res)
  );

  // classify the incoming token and the operands
  always_comb begin
    accept     = in_valid && !in_stall;
    take       = accept && !err && (func != FN_END);
    is_full    = (count >= COUNT_W'(STACK_DEPTH));
    is_bin     = (func >= FN_ADD) && (func <= FN_LOG);
    pow_bad    = opb[WORD_W-1] || ((opa == '0) && (opb == '0));
    log_bad    = opb[WORD_W-1] || (opb < LOG_BASE_MIN) || opa[WORD_W-1] || (opa == '0);
    abs_a      = opa[WORD_W-1] ? (WORD_W'(0) - opa) : opa;
    abs_b      = opb[WORD_W-1] ? (WORD_W'(0) - opb) : opb;
    quo_signed = (opa[WORD_W-1] ^ opb[WORD_W-1]) ? (WORD_W'(0) - alu_res) : alu_res;
    end_bad    = err || (count != COUNT_W'(1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if ((func == FN_SQRT) && (count != '0) && !top[WORD_W-1]) begin
            state_next = ST_ALU_WAIT;
          end else if ((func == FN_SEL) && (count >= COUNT_W'(3))) begin
            state_next = ST_SEL_B;
          end else if (is_bin && (count >= COUNT_W'(2))) begin
            state_next = ST_FETCH_A;
          end
        end
      end
      ST_SEL_B:   state_next = ST_SEL_A;
      ST_SEL_A:   state_next = ST_IDLE;
      ST_FETCH_A: state_next = ST_EXEC;
      ST_EXEC: begin
        priority case (func_reg)
          FN_MUL:  state_next = ST_ALU_WAIT;
          FN_DIV:  state_next = (opb == '0) ? ST_IDLE : ST_ALU_WAIT;
          FN_POW:  state_next = pow_bad ? ST_IDLE : ST_POW_STEP;
          FN_LOG:  state_next = log_bad ? ST_IDLE : ST_LOG_STEP;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_ALU_WAIT: if (alu_rsp.done) state_next = ST_IDLE;
      ST_POW_STEP: begin
        if (opb == '0)  state_next = ST_IDLE;
        else if (opb[0]) state_next = ST_POW_MR;
        else             state_next = ST_POW_MB;
      end
      ST_POW_MR:   if (alu_rsp.done) state_next = ST_POW_MB;
      ST_POW_MB:   if (alu_rsp.done) state_next = ST_POW_STEP;
      ST_LOG_STEP: state_next = (opa >= opb) ? ST_LOG_WAIT : ST_IDLE;
      ST_LOG_WAIT: if (alu_rsp.done) state_next = ST_LOG_STEP;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: stall, ALU requests, stack writes, errors
  always_comb begin
    in_stall    = 1'b1;
    alu_req     = '{start: 1'b0, op: ALU_MUL};
    alu_x       = opa;
    alu_y       = opb;
    push_we     = 1'b0;
    wb_en       = 1'b0;
    wb_data     = acc;
    err_set     = 1'b0;
    rd_addr     = IDX_W'(count - COUNT_W'(2));
    unique case (state)
      ST_IDLE: begin
        in_stall = out_valid && (func == FN_END);
        alu_x    = top;
        if (take) begin
          if (func == FN_PUSH) begin
            push_we = !is_full;
            err_set = is_full;
          end else if (func == FN_SQRT) begin
            if ((count == '0) || top[WORD_W-1]) err_set = 1'b1;
            else alu_req = '{start: 1'b1, op: ALU_SQRT};
          end else if (func == FN_SEL) begin
            err_set = (count < COUNT_W'(3));
          end else if (is_bin) begin
            err_set = (count < COUNT_W'(2));
          end else begin
            err_set = 1'b1;
          end
        end
      end
      ST_SEL_B: rd_addr = IDX_W'(count - COUNT_W'(3));
      ST_SEL_A: begin
        wb_en   = 1'b1;
        wb_data = (rd_data != '0) ? opb : top;
      end
      ST_FETCH_A: ;
      ST_EXEC: begin
        priority case (func_reg)
          FN_ADD: begin
            wb_en   = 1'b1;
            wb_data = opa + opb;
          end
          FN_SUB: begin
            wb_en   = 1'b1;
            wb_data = opa - opb;
          end
          FN_MUL: alu_req = '{start: 1'b1, op: ALU_MUL};
          FN_DIV: begin
            alu_x = abs_a;
            alu_y = abs_b;
            if (opb == '0) err_set = 1'b1;
            else alu_req = '{start: 1'b1, op: ALU_DIV};
          end
          FN_POW:  err_set = pow_bad;
          FN_LOG:  err_set = log_bad;
          default: err_set = 1'b1;
        endcase
      end
      ST_ALU_WAIT: begin
        wb_en   = alu_rsp.done;
        wb_data = (func_reg == FN_DIV) ? quo_signed : alu_res;
      end
      ST_POW_STEP: begin
        if (opb == '0) begin
          wb_en = 1'b1;
        end else if (opb[0]) begin
          alu_x   = acc;
          alu_y   = opa;
          alu_req = '{start: 1'b1, op: ALU_MUL};
        end else begin
          alu_y   = opa;
          alu_req = '{start: 1'b1, op: ALU_MUL};
        end
      end
      ST_POW_MR: begin
        alu_y   = opa;
        alu_req = '{start: alu_rsp.done, op: ALU_MUL};
      end
      ST_POW_MB: ;
      ST_LOG_STEP: begin
        if (opa >= opb) alu_req = '{start: 1'b1, op: ALU_DIV};
        else wb_en = 1'b1;
      end
      ST_LOG_WAIT: ;
      default: ;
    endcase
  end

  // write-back slot and new depth by token kind
  always_comb begin
    priority case (func_reg)
      FN_SQRT: begin
        wb_addr  = IDX_W'(count - COUNT_W'(1));
        wb_count = count;
      end
      FN_SEL: begin
        wb_addr  = IDX_W'(count - COUNT_W'(3));
        wb_count = count - COUNT_W'(2);
      end
      default: begin
        wb_addr  = IDX_W'(count - COUNT_W'(2));
        wb_count = count - COUNT_W'(1);
      end
    endcase
    mem_we    = push_we || wb_en;
    mem_addr  = push_we ? IDX_W'(count) : wb_addr;
    mem_wdata = push_we ? operand_value : wb_data;
  end

  // stack memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (err_set) err <= 1'b1;
      if (push_we) count <= count + COUNT_W'(1);
      if (wb_en) count <= wb_count;
      if (accept && (func == FN_END)) begin
        out_valid <= 1'b1;
        count     <= '0;
        err       <= 1'b0;
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (push_we) top <= operand_value;
    if (wb_en) top <= wb_data;
    if (accept) begin
      func_reg <= func;
      opb      <= top;
    end
    if (accept && (func == FN_END)) begin
      result_value <= end_bad ? '0 : top;
      status       <= end_bad;
    end
    unique case (state)
      ST_FETCH_A: opa <= rd_data;
      ST_SEL_B:   opb <= rd_data;
      ST_EXEC:    acc <= (func_reg == FN_POW) ? WORD_W'(1) : '0;
      ST_POW_MR:  if (alu_rsp.done) acc <= alu_res;
      ST_POW_MB: begin
        if (alu_rsp.done) begin
          opa <= alu_res;
          opb <= opb >> 1;
        end
      end
      ST_LOG_WAIT: begin
        if (alu_rsp.done) begin
          opa <= alu_res;
          acc <= acc + WORD_W'(1);
        end
      end
      default: ;
    endcase
  end

  // stack never grows past its depth
  assert property (@(posedge clk) disable iff (rst) count <= COUNT_W'(STACK_DEPTH))
    else $error("stack count past depth");
  // an error result carries a zero value
  assert property (@(posedge clk) disable iff (rst) (out_valid && status) |-> (result_value == '0))
    else $error("error result with nonzero value");
  // the end token empties the stack and clears the error
  assert property (@(posedge clk) disable iff (rst)
      (accept && (func == FN_END)) |=> ((count == '0) && !err && out_valid))
    else $error("end token did not clear state");
  // results are written back only while a token is in progress
  assert property (@(posedge clk) disable iff (rst) wb_en |-> (state != ST_IDLE))
    else $error("write-back while idle");

endmodule
`default_nettype wire

// ----- tb/sv/tb_rpn_stack_evaluator_top.sv -----
// Self-checking testbench for rpn_stack_evaluator_top: directed tokens with expected
// results, then random expressions checked against an in-bench integer stack predictor.
// Depends on rse_pkg (token codes, widths) and the RTL of the evaluator.
module tb_rpn_stack_evaluator_top;
  import rse_pkg::*;

  localparam logic [3:0] FN_BAD = 4'd10;
  localparam logic [63:0] W_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] W_MIN = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [3:0]  f;
    logic [63:0] v;
    bit          typed;
    logic [63:0] tv;
    bit          ts;
  } token_row_t;

  typedef struct {
    logic [63:0] value;
    bit          err;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] func = FN_PUSH;
  logic signed [63:0] operand_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] result_value;
  logic status;

  // typed expectation travelling with the current token
  bit          cur_typed = 1'b0;
  logic [63:0] cur_tv = '0;
  bit          cur_ts = 1'b0;

  answer_t answers_due[$];
  int      fail_count = 0;
  int      tokens_sent = 0;
  int      answers_seen = 0;
  bit      quiet_phase = 1'b0;

  // predictor state
  logic [63:0] calc_stack [STACK_DEPTH];
  int unsigned calc_depth = 0;
  bit          calc_err = 1'b0;

  rpn_stack_evaluator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .operand_value(operand_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] magnitude(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // Evaluate one token on the predictor stack; emits is set for the end token.
  function automatic void eval_token(input logic [3:0] f, input logic [63:0] v,
                                     output bit emits, output answer_t ans);
    logic [63:0] a, b, c, r, e, bs, x, res, bitv;
    emits = 1'b0;
    ans.value = '0;
    ans.err = 1'b0;
    if (f == FN_END) begin
      emits = 1'b1;
      ans.err = calc_err || calc_depth != 1;
      ans.value = ans.err ? 64'd0 : calc_stack[0];
      calc_depth = 0;
      calc_err = 1'b0;
      return;
    end
    if (calc_err) return;
    case (f)
      FN_PUSH: begin
        if (calc_depth >= STACK_DEPTH) calc_err = 1'b1;
        else begin
          calc_stack[calc_depth] = v;
          calc_depth++;
        end
      end
      FN_SQRT: begin
        if (calc_depth < 1 || calc_stack[calc_depth-1][63]) calc_err = 1'b1;
        else begin
          x = calc_stack[calc_depth-1];
          res = 0;
          bitv = 64'd1 << 62;
          while (bitv > x) bitv >>= 2;
          while (bitv != 0) begin
            if (x >= res + bitv) begin
              x -= res + bitv;
              res = (res >> 1) + bitv;
            end else res >>= 1;
            bitv >>= 2;
          end
          calc_stack[calc_depth-1] = res;
        end
      end
      FN_SEL: begin
        if (calc_depth < 3) calc_err = 1'b1;
        else begin
          c = calc_stack[calc_depth-1];
          b = calc_stack[calc_depth-2];
          a = calc_stack[calc_depth-3];
          calc_depth -= 2;
          calc_stack[calc_depth-1] = (a != 0) ? b : c;
        end
      end
      FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_POW, FN_LOG: begin
        if (calc_depth < 2) begin
          calc_err = 1'b1;
          return;
        end
        b = calc_stack[calc_depth-1];
        a = calc_stack[calc_depth-2];
        r = 0;
        case (f)
          FN_ADD: r = a + b;
          FN_SUB: r = a - b;
          FN_MUL: r = a * b;
          FN_DIV: begin
            if (b == 0) calc_err = 1'b1;
            else begin
              r = magnitude(a) / magnitude(b);
              if (a[63] != b[63]) r = 64'd0 - r;
            end
          end
          FN_POW: begin
            if (b[63] || (a == 0 && b == 0)) calc_err = 1'b1;
            else begin
              r = 1;
              bs = a;
              e = b;
              while (e != 0) begin
                if (e[0]) r = r * bs;
                bs = bs * bs;
                e >>= 1;
              end
            end
          end
          default: begin
            if (b[63] || b < 2 || a[63] || a == 0) calc_err = 1'b1;
            else begin
              x = a;
              while (x >= b) begin
                x = x / b;
                r++;
              end
            end
          end
        endcase
        if (!calc_err) begin
          calc_depth--;
          calc_stack[calc_depth-1] = r;
        end
      end
      default: calc_err = 1'b1;
    endcase
  endfunction

  // Track transfers on both channels; compare results against the oldest answer.
  always @(posedge clk) begin
    bit emits;
    answer_t ans, want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        eval_token(func, operand_value, emits, ans);
        if (emits) begin
          if (cur_typed) begin
            ans.value = cur_tv;
            ans.err = cur_ts;
          end
          answers_due.push_back(ans);
        end
      end
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (answers_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result value=%0d status=%0d", $time,
                   result_value, status);
        end else begin
          want = answers_due.pop_front();
          if (result_value !== want.value) begin
            fail_count++;
            $display("%0t: result_value expected %0d actual %0d", $time,
                     $signed(want.value), result_value);
          end
          if (status !== want.err) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.err, status);
          end
        end
      end
    end
  end

  // Stall the result side in random stretches, with calm phases.
  always @(posedge clk) begin
    if (quiet_phase) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 99) < 30) out_stall <= 1'b0;
    else if (!out_stall) out_stall <= ($urandom_range(0, 99) < 25);
  end

  function automatic int pick_gap();
    int p;
    if (quiet_phase) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one token and hold it until the transfer.
  task automatic send(input logic [3:0] f, input logic [63:0] v,
                      input bit t = 1'b0, input logic [63:0] tv = '0, input bit ts = 1'b0);
    int gap;
    in_valid <= 1'b1;
    func <= f;
    operand_value <= v;
    cur_typed <= t;
    cur_tv <= tv;
    cur_ts <= ts;
    do @(posedge clk); while (in_stall);
    tokens_sent++;
    if (tokens_sent % 200 == 0) quiet_phase = !quiet_phase;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return W_MAX;
      1: return W_MIN;
      2: return 64'd0;
      3: return '1;
      4, 5, 6: return 64'($signed($urandom_range(0, 100)) - 50);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Build one expression with random content, at times with a stray sub, then end it.
  task automatic send_expression();
    int n, d, op;
    logic [63:0] w;
    n = $urandom_range(1, 8);
    d = 0;
    repeat (n) begin
      while (d < 3 || $urandom_range(0, 3) == 0) begin
        if (d >= STACK_DEPTH - 2) break;
        send(FN_PUSH, rand_word());
        d++;
      end
      op = $urandom_range(1, 8);
      case (op)
        1: send(FN_ADD, rand_word());
        2: send(FN_SUB, rand_word());
        3: send(FN_MUL, rand_word());
        4: begin
          w = ($urandom_range(0, 9) == 0) ? 64'd0 : rand_word();
          send(FN_PUSH, w);
          d++;
          send(FN_DIV, rand_word());
        end
        5: begin
          // exponent mostly small: the block squares once per exponent bit
          w = ($urandom_range(0, 49) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, 20));
          send(FN_PUSH, w);
          d++;
          send(FN_POW, rand_word());
        end
        6: begin
          w = ($urandom_range(0, 9) == 0) ? 64'($signed($urandom_range(0, 4)) - 2)
                                           : 64'($urandom_range(2, 1000));
          send(FN_PUSH, w);
          d++;
          send(FN_LOG, rand_word());
        end
        7: send(FN_SQRT, rand_word());
        default: send(FN_SEL, rand_word());
      endcase
      if (op == 8) d -= 2;
      else if (op != 7) d -= 1;
    end
    if ($urandom_range(0, 4) == 0) send(FN_SUB, rand_word());
    send(FN_END, rand_word());
  endtask

  initial begin
    token_row_t rows[$];
    bit pressure_done;
    pressure_done = 1'b0;
    rows = '{
      '{FN_END, 64'd5, 1, 64'd0, 1},
      '{FN_PUSH, W_MAX, 0, 0, 0}, '{FN_PUSH, 64'd1, 0, 0, 0},
      '{FN_ADD, 0, 0, 0, 0}, '{FN_END, 0, 1, W_MIN, 0},
      '{FN_PUSH, W_MIN, 0, 0, 0}, '{FN_PUSH, '1, 0, 0, 0},
      '{FN_DIV, 0, 0, 0, 0}, '{FN_END, 0, 1, W_MIN, 0},
      '{FN_PUSH, 64'd7, 0, 0, 0}, '{FN_PUSH, 64'd0, 0, 0, 0},
      '{FN_DIV, 0, 0, 0, 0}, '{FN_END, 0, 1, 64'd0, 1},
      '{FN_PUSH, -64'sd4, 0, 0, 0}, '{FN_SQRT, 0, 0, 0, 0}, '{FN_END, 0, 1, 64'd0, 1},
      '{FN_PUSH, 64'd0, 0, 0, 0}, '{FN_PUSH, 64'd0, 0, 0, 0},
      '{FN_POW, 0, 0, 0, 0}, '{FN_END, 0, 1, 64'd0, 1},
      '{FN_PUSH, 64'd100, 0, 0, 0}, '{FN_PUSH, 64'd10, 0, 0, 0}, '{FN_LOG, 0, 0, 0, 0},
      '{FN_PUSH, 64'd3, 0, 0, 0}, '{FN_POW, 0, 0, 0, 0},
      '{FN_PUSH, 64'd9, 0, 0, 0}, '{FN_SUB, 0, 0, 0, 0},
      '{FN_PUSH, 64'd2, 0, 0, 0}, '{FN_MUL, 0, 0, 0, 0},
      '{FN_PUSH, 64'd5, 0, 0, 0}, '{FN_PUSH, 64'd6, 0, 0, 0},
      '{FN_SEL, 0, 0, 0, 0}, '{FN_END, 0, 1, 64'd5, 0},
      '{FN_BAD, '1, 0, 0, 0}, '{FN_END, 0, 1, 64'd0, 1},
      '{4'd15, 0, 0, 0, 0}, '{FN_END, 0, 1, 64'd0, 1}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    foreach (rows[i]) send(rows[i].f, rows[i].v, rows[i].typed, rows[i].tv, rows[i].ts);

    // fill the stack past its depth, then close with an end token
    repeat (STACK_DEPTH + 2) send(FN_PUSH, rand_word());
    send(FN_END, 0);

    // random part: mostly well-formed expressions, some noise
    while (tokens_sent < 1600) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) send(4'($urandom_range(0, 15)), rand_word());
      else send_expression();
      // hold the sender once until every result has drained
      if (!pressure_done && tokens_sent > 800) begin
        pressure_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (answers_due.size() == 0);
        @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // drain and let the block settle
    @(posedge clk);
    wait (answers_due.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d tokens, checked %0d results (directed table, stack overflow,",
             tokens_sent, answers_seen);
    $display("random expressions with noise, random stalls on both sides).");
    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #1_000_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rse_pkg.sv
rtl/rse_alu.sv
rtl/rpn_stack_evaluator_top.sv
tb/sv/tb_rpn_stack_evaluator_top.sv
